// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the particle step unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the asynchronous reset is asserted.
`define ECPS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Overlapping implication built on the macro above.
`define ECPS_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	`ECPS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== sv/ecps_pkg.sv =====
// ----------------------------------------------------------------------------
// ecps_pkg
// Types, widths and helpers of the elastic collision particle step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecps_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int MASSW       = 16;
	localparam int TIMEW       = 32;

	// Differences of two values and their magnitudes.
	localparam int MW    = VALUE_WIDTH + 1;
	// Squares and cross products of magnitudes.
	localparam int SQW   = 2 * MW;
	localparam int HALFW = MW;
	localparam int MSUMW = MASSW + 1;
	// Collision denominator d2 * (m1 + m2).
	localparam int DENW  = SQW + MSUMW;
	// Twice the dot product times one distance component.
	localparam int BW    = SQW + MW + 1;
	localparam int PARTW = (BW + 2) / 3;
	localparam int NUMW  = BW + MASSW;
	// Divider: quotient bits, divisor width, dividend width.
	localparam int QW    = VALUE_WIDTH + 1;
	localparam int DDW   = DENW + 1;
	localparam int NW    = DDW + QW;
	// Signed width that holds every sum before saturation.
	localparam int EXTW  = 2 * VALUE_WIDTH - FRAC_BITS + 3;

	localparam logic [MASSW-1:0] OWN_MASS_RESET = MASSW'(10);

	localparam logic [2*VALUE_WIDTH:0] RND_HALF =
		(2 * VALUE_WIDTH + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [QW-1:0] QSPAN = QW'(1) << VALUE_WIDTH;

	localparam logic signed [EXTW-1:0] VMAX_E =
		{{(EXTW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
	localparam logic signed [EXTW-1:0] VMIN_E = ~VMAX_E;

	typedef enum logic [1:0] {
		MODE_COLLIDE  = 2'd0,
		MODE_REFLECTX = 2'd1,
		MODE_REFLECTY = 2'd2,
		MODE_ADVANCE  = 2'd3
	} mode_t;

	typedef logic signed [VALUE_WIDTH-1:0] val_t;

	typedef struct packed {
		mode_t              mode;
		val_t               self_x;
		val_t               self_y;
		val_t               self_vx;
		val_t               self_vy;
		val_t               other_x;
		val_t               other_y;
		val_t               other_vx;
		val_t               other_vy;
		logic [MASSW-1:0]   other_mass;
		logic [TIMEW-1:0]   step_time;
		logic               partner_present;
	} req_t;

	typedef struct packed {
		val_t new_x;
		val_t new_y;
		val_t new_vx;
		val_t new_vy;
		val_t other_new_vx;
		val_t other_new_vy;
		logic coincident;
	} rsp_t;

	// Result that holds unless a collision overrides the velocities.
	typedef struct packed {
		rsp_t res;
		logic coll;
		logic negx;
		logic negy;
	} meta_t;

	function automatic logic signed [EXTW-1:0] ext_val(input val_t v);
		return {{(EXTW - VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
	endfunction

	function automatic val_t sat_val(input logic signed [EXTW-1:0] v);
		if (v > VMAX_E) begin
			return VMAX_E[VALUE_WIDTH-1:0];
		end else if (v < VMIN_E) begin
			return VMIN_E[VALUE_WIDTH-1:0];
		end
		return v[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
		return v[MW-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

`default_nettype wire

// ===== sv/elastic_collision_particle_step_unit.sv =====
// ----------------------------------------------------------------------------
// elastic_collision_particle_step_unit
// One motion or collision step of a particle in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A request is taken on the rising edge where start is high and busy is low.
// It carries the particle, its partner and a mode: collide along the line of
// centers, reflect at an x or a y border, or advance the position by velocity
// times step time. Every request gives exactly one result, shown on rsp for
// one cycle while rsp_strobe is high; the receiver cannot hold it off.
// The unit is a pipeline that never stalls: a new request may enter every
// cycle, so the sustained rate is one request per clock. Nine stages form the
// differences, squares, products and the collision numerators and the
// denominator; then four pipelined restoring dividers, one quotient bit per
// stage (34 stages including the overflow check), do the exact rounding
// divisions; a last stage applies signs and saturates. The dividers set the
// depth. The mass of the moving particle, shared by its kind, is the one
// configuration register, written through cfg_wr_en and cfg_wr_data; the
// user must write it only while no request is in flight, and the block does
// not enforce this. Reset clears all valid bits, sets the mass to 10 and
// holds busy high until the first clock edge after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module elastic_collision_particle_step_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire ecps_pkg::req_t              req,
	input  wire logic                        cfg_wr_en,
	input  wire logic [ecps_pkg::MASSW-1:0]  cfg_wr_data,
	output logic                             rsp_strobe,
	output ecps_pkg::rsp_t                   rsp
);

	localparam int DIV_LAT = ecps_pkg::QW + 1;
	localparam int LATENCY = 9 + DIV_LAT + 1;
	localparam int MW      = ecps_pkg::MW;
	localparam int SQW     = ecps_pkg::SQW;
	localparam int HALFW   = ecps_pkg::HALFW;
	localparam int PARTW   = ecps_pkg::PARTW;
	localparam int PPW     = PARTW + ecps_pkg::MASSW;
	localparam int VW      = ecps_pkg::VALUE_WIDTH;
	localparam int EXTW    = ecps_pkg::EXTW;

	logic                       busy_q;
	logic [ecps_pkg::MASSW-1:0] own_mass_q;

	// Busy is only raised while reset is asserted and until the first clock edge after its release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			own_mass_q <= ecps_pkg::OWN_MASS_RESET;
		end else begin
			busy_q <= 1'b0;
			if (cfg_wr_en) begin
				own_mass_q <= cfg_wr_data;
			end
		end
	end

	assign busy = busy_q;

	// Valid bits of the front stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Stage 1: capture the request.
	ecps_pkg::req_t req_s1;

	always_ff @(posedge clk) begin
		req_s1 <= req;
	end

	// Stage 2: center distance and relative velocity, split into magnitude
	// and sign so that all later products are unsigned.
	logic signed [MW-1:0] dx_c, dy_c, dvx_c, dvy_c;
	ecps_pkg::req_t       req_s2;
	logic [MW-1:0]        mdx_s2, mdy_s2, mdvx_s2, mdvy_s2, msvx_s2, msvy_s2;
	logic                 ndx_s2, ndy_s2, ndvx_s2, ndvy_s2;

	always_comb begin
		dx_c  = {req_s1.other_x[VW-1], req_s1.other_x} -
			{req_s1.self_x[VW-1], req_s1.self_x};
		dy_c  = {req_s1.other_y[VW-1], req_s1.other_y} -
			{req_s1.self_y[VW-1], req_s1.self_y};
		dvx_c = {req_s1.self_vx[VW-1], req_s1.self_vx} -
			{req_s1.other_vx[VW-1], req_s1.other_vx};
		dvy_c = {req_s1.self_vy[VW-1], req_s1.self_vy} -
			{req_s1.other_vy[VW-1], req_s1.other_vy};
	end

	always_ff @(posedge clk) begin
		req_s2  <= req_s1;
		mdx_s2  <= ecps_pkg::mag(dx_c);
		mdy_s2  <= ecps_pkg::mag(dy_c);
		mdvx_s2 <= ecps_pkg::mag(dvx_c);
		mdvy_s2 <= ecps_pkg::mag(dvy_c);
		msvx_s2 <= ecps_pkg::mag({req_s1.self_vx[VW-1], req_s1.self_vx});
		msvy_s2 <= ecps_pkg::mag({req_s1.self_vy[VW-1], req_s1.self_vy});
		ndx_s2  <= dx_c[MW-1];
		ndy_s2  <= dy_c[MW-1];
		ndvx_s2 <= dvx_c[MW-1];
		ndvy_s2 <= dvy_c[MW-1];
	end

	// Stage 3: squares, cross products and the advance displacements.
	ecps_pkg::req_t  req_s3;
	logic [SQW-1:0]  sqx_s3, sqy_s3, p1_s3, p2_s3;
	logic [2*VW-1:0] mtx_s3, mty_s3;
	logic [MW-1:0]   mdx_s3, mdy_s3;
	logic            ndx_s3, ndy_s3, s1_s3, s2_s3;

	always_ff @(posedge clk) begin
		req_s3 <= req_s2;
		sqx_s3 <= mdx_s2 * mdx_s2;
		sqy_s3 <= mdy_s2 * mdy_s2;
		p1_s3  <= mdvx_s2 * mdx_s2;
		p2_s3  <= mdvy_s2 * mdy_s2;
		mtx_s3 <= msvx_s2[VW-1:0] * req_s2.step_time;
		mty_s3 <= msvy_s2[VW-1:0] * req_s2.step_time;
		mdx_s3 <= mdx_s2;
		mdy_s3 <= mdy_s2;
		ndx_s3 <= ndx_s2;
		ndy_s3 <= ndy_s2;
		s1_s3  <= ndvx_s2 ^ ndx_s2;
		s2_s3  <= ndvy_s2 ^ ndy_s2;
	end

	// Stage 4: squared distance, signed dot product, and the complete result
	// of every case that does not need a division.
	logic [SQW:0]                  d2_sum, sm_sum, sm_d12, sm_d21;
	logic [SQW-1:0]                smag_c;
	logic                          sneg_c;
	logic [ecps_pkg::MSUMW-1:0]    msum_c;
	logic [2*VW:0]                 rx_c, ry_c;
	logic signed [EXTW-1:0]        ax_c, ay_c;
	logic                          zero_c, pair_c;
	ecps_pkg::meta_t               meta_c;

	always_comb begin
		d2_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};
		sm_sum = {1'b0, p1_s3} + {1'b0, p2_s3};
		sm_d12 = {1'b0, p1_s3} - {1'b0, p2_s3};
		sm_d21 = {1'b0, p2_s3} - {1'b0, p1_s3};
		priority if (s1_s3 == s2_s3) begin
			smag_c = sm_sum[SQW-1:0];
			sneg_c = s1_s3;
		end else if (p1_s3 >= p2_s3) begin
			smag_c = sm_d12[SQW-1:0];
			sneg_c = s1_s3;
		end else begin
			smag_c = sm_d21[SQW-1:0];
			sneg_c = s2_s3;
		end
		msum_c = {1'b0, own_mass_q} + {1'b0, req_s3.other_mass};

		// Advance: round the velocity-time product to nearest, ties away
		// from zero, on the magnitude.
		rx_c = {1'b0, mtx_s3} + ecps_pkg::RND_HALF;
		ry_c = {1'b0, mty_s3} + ecps_pkg::RND_HALF;
		ax_c = EXTW'(rx_c[2*VW:ecps_pkg::FRAC_BITS]);
		ay_c = EXTW'(ry_c[2*VW:ecps_pkg::FRAC_BITS]);
		if (req_s3.self_vx[VW-1]) begin
			ax_c = -ax_c;
		end
		if (req_s3.self_vy[VW-1]) begin
			ay_c = -ay_c;
		end

		zero_c = (d2_sum == '0);
		pair_c = (req_s3.mode == ecps_pkg::MODE_COLLIDE) && req_s3.partner_present;

		meta_c.res.new_x        = req_s3.self_x;
		meta_c.res.new_y        = req_s3.self_y;
		meta_c.res.new_vx       = req_s3.self_vx;
		meta_c.res.new_vy       = req_s3.self_vy;
		meta_c.res.other_new_vx = req_s3.other_vx;
		meta_c.res.other_new_vy = req_s3.other_vy;
		meta_c.res.coincident   = pair_c && zero_c;
		meta_c.coll             = pair_c && !zero_c && (msum_c != '0);
		meta_c.negx             = sneg_c ^ ndx_s3;
		meta_c.negy             = sneg_c ^ ndy_s3;

		unique case (req_s3.mode)
			ecps_pkg::MODE_REFLECTX: begin
				meta_c.res.new_vx = ecps_pkg::sat_val(-ecps_pkg::ext_val(req_s3.self_vx));
			end
			ecps_pkg::MODE_REFLECTY: begin
				meta_c.res.new_vy = ecps_pkg::sat_val(-ecps_pkg::ext_val(req_s3.self_vy));
			end
			ecps_pkg::MODE_ADVANCE: begin
				meta_c.res.new_x = ecps_pkg::sat_val(ecps_pkg::ext_val(req_s3.self_x) + ax_c);
				meta_c.res.new_y = ecps_pkg::sat_val(ecps_pkg::ext_val(req_s3.self_y) + ay_c);
			end
			default: begin
			end
		endcase
	end

	ecps_pkg::meta_t            meta_s4;
	logic [SQW-1:0]             d2_s4, smag_s4;
	logic [ecps_pkg::MSUMW-1:0] msum_s4;
	logic [MW-1:0]              mdx_s4, mdy_s4;
	logic [ecps_pkg::MASSW-1:0] m1_s4, m2_s4;

	always_ff @(posedge clk) begin
		meta_s4 <= meta_c;
		d2_s4   <= d2_sum[SQW-1:0];
		smag_s4 <= smag_c;
		msum_s4 <= msum_c;
		mdx_s4  <= mdx_s3;
		mdy_s4  <= mdy_s3;
		m1_s4   <= own_mass_q;
		m2_s4   <= req_s3.other_mass;
	end

	// Stage 5: partial products of the denominator and of the dot product times
	// each distance component, d2 and the dot magnitude each split in two halves.
	ecps_pkg::meta_t                  meta_s5;
	logic [HALFW+ecps_pkg::MSUMW-1:0] denlo_s5, denhi_s5;
	logic [2*HALFW-1:0]               bl_s5 [2];
	logic [2*HALFW-1:0]               bh_s5 [2];
	logic [ecps_pkg::MASSW-1:0]       m1_s5, m2_s5;

	always_ff @(posedge clk) begin
		meta_s5  <= meta_s4;
		denlo_s5 <= d2_s4[HALFW-1:0] * msum_s4;
		denhi_s5 <= d2_s4[SQW-1:HALFW] * msum_s4;
		bl_s5[0] <= smag_s4[HALFW-1:0] * mdx_s4;
		bh_s5[0] <= smag_s4[SQW-1:HALFW] * mdx_s4;
		bl_s5[1] <= smag_s4[HALFW-1:0] * mdy_s4;
		bh_s5[1] <= smag_s4[SQW-1:HALFW] * mdy_s4;
		m1_s5    <= m1_s4;
		m2_s5    <= m2_s4;
	end

	// Stage 6: assemble the denominator and twice the projected products.
	ecps_pkg::meta_t              meta_s6;
	logic [ecps_pkg::DENW-1:0]    den_s6;
	logic [ecps_pkg::BW-1:0]      b_s6 [2];
	logic [ecps_pkg::MASSW-1:0]   m1_s6, m2_s6;

	always_ff @(posedge clk) begin
		meta_s6 <= meta_s5;
		den_s6  <= ecps_pkg::DENW'(denlo_s5) + (ecps_pkg::DENW'(denhi_s5) << HALFW);
		for (int a = 0; a < 2; a++) begin
			b_s6[a] <= (ecps_pkg::BW'(bl_s5[a]) + (ecps_pkg::BW'(bh_s5[a]) << HALFW)) << 1;
		end
		m1_s6 <= m1_s5;
		m2_s6 <= m2_s5;
	end

	// Stage 7: numerator partial products. Index 2*axis+0 is the particle
	// (weighted by the partner mass), 2*axis+1 the partner (own mass).
	ecps_pkg::meta_t           meta_s7;
	logic [ecps_pkg::DENW-1:0] den_s7;
	logic [PPW-1:0]            pp_s7 [4][3];
	logic [3*PARTW-1:0]        bext [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			bext[a] = (3 * PARTW)'(b_s6[a]);
		end
	end

	always_ff @(posedge clk) begin
		meta_s7 <= meta_s6;
		den_s7  <= den_s6;
		for (int a = 0; a < 2; a++) begin
			for (int k = 0; k < 3; k++) begin
				pp_s7[2*a][k]   <= bext[a][k*PARTW +: PARTW] * m2_s6;
				pp_s7[2*a+1][k] <= bext[a][k*PARTW +: PARTW] * m1_s6;
			end
		end
	end

	// Stage 8: sum the partial products into the four numerators.
	ecps_pkg::meta_t           meta_s8;
	logic [ecps_pkg::DENW-1:0] den_s8;
	logic [ecps_pkg::NUMW-1:0] num_s8 [4];

	always_ff @(posedge clk) begin
		meta_s8 <= meta_s7;
		den_s8  <= den_s7;
		for (int i = 0; i < 4; i++) begin
			num_s8[i] <= ecps_pkg::NUMW'(pp_s7[i][0]) +
				(ecps_pkg::NUMW'(pp_s7[i][1]) << PARTW) +
				(ecps_pkg::NUMW'(pp_s7[i][2]) << (2 * PARTW));
		end
	end

	// Stage 9: round(n / den) becomes floor((2n + den) / 2den).
	ecps_pkg::meta_t          meta_s9;
	logic [ecps_pkg::NW-1:0]  nn_s9 [4];
	logic [ecps_pkg::DDW-1:0] dd_s9;

	always_ff @(posedge clk) begin
		meta_s9 <= meta_s8;
		dd_s9   <= {den_s8, 1'b0};
		for (int i = 0; i < 4; i++) begin
			nn_s9[i] <= {num_s8[i], 1'b0} + ecps_pkg::NW'(den_s8);
		end
	end

	// Dividers, and the result shift line that keeps pace with them.
	logic [ecps_pkg::QW-1:0] quo [4];
	logic [3:0]              ovf;
	logic [3:0]              dvld;

	for (genvar i = 0; i < 4; i++) begin : g_div
		ecps_divider #(
			.NW(ecps_pkg::NW),
			.DW(ecps_pkg::DDW),
			.QW(ecps_pkg::QW)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_s9),
			.num      (nn_s9[i]),
			.den      (dd_s9),
			.out_valid(dvld[i]),
			.quo      (quo[i]),
			.ovf      (ovf[i])
		);
	end

	ecps_pkg::meta_t meta_d_q [DIV_LAT];

	always_ff @(posedge clk) begin
		meta_d_q[0] <= meta_s9;
		for (int k = 1; k < DIV_LAT; k++) begin
			meta_d_q[k] <= meta_d_q[k-1];
		end
	end

	// Output stage: clamp quotients that overflow, apply the signs, subtract from
	// the particle's old velocities or add to the partner's, and saturate.
	logic signed [EXTW-1:0] dv_c [4];
	logic                   neg_c;
	ecps_pkg::meta_t        mo;
	ecps_pkg::rsp_t         rsp_c;

	assign mo = meta_d_q[DIV_LAT-1];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			neg_c    = (i < 2) ? mo.negx : mo.negy;
			dv_c[i]  = EXTW'(ovf[i] ? ecps_pkg::QSPAN : quo[i]);
			if (neg_c) begin
				dv_c[i] = -dv_c[i];
			end
		end
		rsp_c = mo.res;
		if (mo.coll) begin
			rsp_c.new_vx       = ecps_pkg::sat_val(ecps_pkg::ext_val(mo.res.new_vx) - dv_c[0]);
			rsp_c.other_new_vx = ecps_pkg::sat_val(
				ecps_pkg::ext_val(mo.res.other_new_vx) + dv_c[1]);
			rsp_c.new_vy       = ecps_pkg::sat_val(ecps_pkg::ext_val(mo.res.new_vy) - dv_c[2]);
			rsp_c.other_new_vy = ecps_pkg::sat_val(
				ecps_pkg::ext_val(mo.res.other_new_vy) + dv_c[3]);
		end
	end

	always_ff @(posedge clk) begin
		rsp <= rsp_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_strobe <= 1'b0;
		end else begin
			rsp_strobe <= dvld[0];
		end
	end

	`ECPS_ASSERT(a_fixed_latency, clk, arst_n, start && !busy |-> ##LATENCY rsp_strobe,
		"accepted request did not produce a result at the fixed latency")

	`ECPS_IMPLY(a_coinc_not_coll, clk, arst_n, v_s4 && meta_s4.res.coincident,
		!meta_s4.coll, "coincident centers routed into the collision path")

	`ECPS_IMPLY(a_dividers_aligned, clk, arst_n, dvld[0],
		dvld[1] && dvld[2] && dvld[3], "dividers out of step")

endmodule

`default_nettype wire

// ===== sv/ecps_divider.sv =====
// ----------------------------------------------------------------------------
// ecps_divider
// Pipelined restoring divider, one quotient bit per stage, with overflow.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ecps_divider #(
	parameter int NW = ecps_pkg::NW,
	parameter int DW = ecps_pkg::DDW,
	parameter int QW = ecps_pkg::QW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               out_valid,
	output logic [QW-1:0]      quo,
	output logic               ovf
);

	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] low_s [QW+1];
	logic [QW-1:0] q_s   [QW+1];
	logic [DW-1:0] d_s   [QW+1];
	logic          ovf_s [QW+1];
	logic          vld_s [QW+1];

	// The quotient fits QW bits exactly when the upper dividend part is below
	// the divisor; otherwise the caller clamps.
	always_ff @(posedge clk) begin
		rem_s[0] <= num[NW-1:QW];
		low_s[0] <= num[QW-1:0];
		q_s[0]   <= '0;
		d_s[0]   <= den;
		ovf_s[0] <= (num[NW-1:QW] >= den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		assign trial = {rem_s[k], low_s[k][QW-1]};
		assign diff  = trial - {1'b0, d_s[k]};
		assign ge    = (trial >= {1'b0, d_s[k]});

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			low_s[k+1] <= low_s[k] << 1;
			q_s[k+1]   <= {q_s[k][QW-2:0], ge};
			d_s[k+1]   <= d_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = q_s[QW];
	assign ovf       = ovf_s[QW];

	`ECPS_IMPLY(a_rem_below_divisor, clk, arst_n, vld_s[QW] && !ovf_s[QW],
		rem_s[QW] < d_s[QW], "divider remainder not below divisor")

endmodule

`default_nettype wire

// ===== tb/sv/elastic_collision_particle_step_unit_test.sv =====
// ----------------------------------------------------------------------------
// elastic_collision_particle_step_unit_test
// Self-checking bench for the particle step unit: a directed table, then
// random requests under several own masses, every result without a typed-in
// answer checked against an exact wide-integer computation of the step.
// ----------------------------------------------------------------------------
`default_nettype none

module elastic_collision_particle_step_unit_test;

	// Wide signed scratch type: every intermediate of the collision fits.
	typedef logic signed [159:0] wide_t;

	localparam ecps_pkg::val_t VMAX = 32'sh7FFF_FFFF;
	localparam ecps_pkg::val_t VMIN = 32'sh8000_0000;
	localparam ecps_pkg::val_t ONE  = 32'sh0001_0000;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	ecps_pkg::req_t              req;
	logic                        cfg_wr_en;
	logic [ecps_pkg::MASSW-1:0]  cfg_wr_data;
	logic                        rsp_strobe;
	ecps_pkg::rsp_t              rsp;

	elastic_collision_particle_step_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.rsp_strobe(rsp_strobe),
		.rsp(rsp)
	);

	// Mass of the moving particle as the unit should currently hold it.
	logic [ecps_pkg::MASSW-1:0] mass_now;
	// Results still owed by the unit, oldest first.
	ecps_pkg::rsp_t             pending_steps[$];
	int                         fail_count;

	// Directed stimulus: requests plus, where obvious, the typed-in answer.
	ecps_pkg::req_t             dir_req[$];
	logic                       dir_known[$];
	ecps_pkg::rsp_t             dir_rsp[$];

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Clamp an exact value to the signed Q16.16 range.
	function automatic ecps_pkg::val_t clamp_val(input wide_t v);
		if (v > wide_t'(VMAX)) begin
			return VMAX;
		end else if (v < wide_t'(VMIN)) begin
			return VMIN;
		end
		return v[31:0];
	endfunction

	// Magnitude limited to 2^32, the largest step the unit ever adds.
	function automatic wide_t limit_step(input wide_t q, input logic neg);
		wide_t cap;
		cap = wide_t'(1) <<< 32;
		if (q > cap) begin
			q = cap;
		end
		return neg ? -q : q;
	endfunction

	// round(num / den) with ties away from zero, on nonnegative operands.
	function automatic wide_t round_quot(input wide_t num, input wide_t den, input logic neg);
		return limit_step((2 * num + den) / (2 * den), neg);
	endfunction

	function automatic wide_t abs_w(input wide_t v);
		return v < 0 ? -v : v;
	endfunction

	// Displacement velocity * time, rounded half away from zero.
	function automatic wide_t travel(input ecps_pkg::val_t v,
			input logic [ecps_pkg::TIMEW-1:0] t);
		wide_t a;
		a = abs_w(wide_t'(v)) * $signed({128'b0, t});
		a = (a + (wide_t'(1) <<< (ecps_pkg::FRAC_BITS - 1))) >>> ecps_pkg::FRAC_BITS;
		return limit_step(a, v < 0);
	endfunction

	// Expected result of one request under own mass m1 of this kind.
	function automatic ecps_pkg::rsp_t step_result(input ecps_pkg::req_t r,
			input logic [ecps_pkg::MASSW-1:0] m1);
		ecps_pkg::rsp_t o;
		wide_t          dx, dy, dvx, dvy, dist2, dot, den, m1w, m2w, base;
		logic           neg;
		o.new_x        = r.self_x;
		o.new_y        = r.self_y;
		o.new_vx       = r.self_vx;
		o.new_vy       = r.self_vy;
		o.other_new_vx = r.other_vx;
		o.other_new_vy = r.other_vy;
		o.coincident   = 1'b0;
		m1w = $signed({144'b0, m1});
		m2w = $signed({144'b0, r.other_mass});
		case (r.mode)
			ecps_pkg::MODE_REFLECTX: begin
				o.new_vx = clamp_val(-wide_t'(r.self_vx));
			end
			ecps_pkg::MODE_REFLECTY: begin
				o.new_vy = clamp_val(-wide_t'(r.self_vy));
			end
			ecps_pkg::MODE_ADVANCE: begin
				o.new_x = clamp_val(wide_t'(r.self_x) + travel(r.self_vx, r.step_time));
				o.new_y = clamp_val(wide_t'(r.self_y) + travel(r.self_vy, r.step_time));
			end
			default: begin
				if (r.partner_present) begin
					dx    = wide_t'(r.other_x) - wide_t'(r.self_x);
					dy    = wide_t'(r.other_y) - wide_t'(r.self_y);
					dvx   = wide_t'(r.self_vx) - wide_t'(r.other_vx);
					dvy   = wide_t'(r.self_vy) - wide_t'(r.other_vy);
					dist2 = dx * dx + dy * dy;
					dot   = dvx * dx + dvy * dy;
					if (dist2 == 0) begin
						o.coincident = 1'b1;
					end else if (m1w + m2w != 0) begin
						den = dist2 * (m1w + m2w);
						// Impulse along x: sign follows dot product times dx.
						base = 2 * abs_w(dot) * abs_w(dx);
						neg  = (dot < 0) != (dx < 0);
						o.new_vx = clamp_val(wide_t'(r.self_vx)
							- round_quot(base * m2w, den, neg));
						o.other_new_vx = clamp_val(wide_t'(r.other_vx)
							+ round_quot(base * m1w, den, neg));
						base = 2 * abs_w(dot) * abs_w(dy);
						neg  = (dot < 0) != (dy < 0);
						o.new_vy = clamp_val(wide_t'(r.self_vy)
							- round_quot(base * m2w, den, neg));
						o.other_new_vy = clamp_val(wide_t'(r.other_vy)
							+ round_quot(base * m1w, den, neg));
					end
				end
			end
		endcase
		return o;
	endfunction

	// Result in which every field simply passes through.
	function automatic ecps_pkg::rsp_t unchanged(input ecps_pkg::req_t r, input logic coinc);
		ecps_pkg::rsp_t o;
		o.new_x        = r.self_x;
		o.new_y        = r.self_y;
		o.new_vx       = r.self_vx;
		o.new_vy       = r.self_vy;
		o.other_new_vx = r.other_vx;
		o.other_new_vy = r.other_vy;
		o.coincident   = coinc;
		return o;
	endfunction

	function automatic ecps_pkg::req_t make_req(input ecps_pkg::mode_t m,
			input ecps_pkg::val_t x, input ecps_pkg::val_t y,
			input ecps_pkg::val_t vx, input ecps_pkg::val_t vy,
			input ecps_pkg::val_t ox, input ecps_pkg::val_t oy,
			input ecps_pkg::val_t ovx, input ecps_pkg::val_t ovy,
			input logic [ecps_pkg::MASSW-1:0] om,
			input logic [ecps_pkg::TIMEW-1:0] t, input logic present);
		ecps_pkg::req_t r;
		r.mode            = m;
		r.self_x          = x;
		r.self_y          = y;
		r.self_vx         = vx;
		r.self_vy         = vy;
		r.other_x         = ox;
		r.other_y         = oy;
		r.other_vx        = ovx;
		r.other_vy        = ovy;
		r.other_mass      = om;
		r.step_time       = t;
		r.partner_present = present;
		return r;
	endfunction

	task automatic add_row(input ecps_pkg::req_t r, input logic known,
			input ecps_pkg::rsp_t answer);
		dir_req.push_back(r);
		dir_known.push_back(known);
		dir_rsp.push_back(answer);
	endtask

	// Mostly back-to-back, sometimes a short pause, rarely a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// A value drawn from full range, small numbers or the extremes.
	function automatic ecps_pkg::val_t pick_val();
		case ($urandom_range(0, 9))
			0, 1, 2: return ecps_pkg::val_t'($urandom);
			3, 4, 5: return ecps_pkg::val_t'($signed($urandom_range(0, 32'h0020_0000))
				- 32'sh0010_0000);
			6: begin
				case ($urandom_range(0, 3))
					0: return VMAX;
					1: return VMIN;
					2: return ecps_pkg::val_t'(0);
					default: return ecps_pkg::val_t'(-1);
				endcase
			end
			default: return ecps_pkg::val_t'($signed($urandom_range(0, 2000)) - 1000)
				<<< ecps_pkg::FRAC_BITS;
		endcase
	endfunction

	function automatic logic [ecps_pkg::MASSW-1:0] pick_mass();
		case ($urandom_range(0, 7))
			0: return ecps_pkg::MASSW'(1);
			1: return ecps_pkg::MASSW'(65535);
			default: return ecps_pkg::MASSW'($urandom_range(1, 65535));
		endcase
	endfunction

	// Random request; collisions mostly have a nearby partner so the
	// impulse is meaningful rather than always saturated.
	function automatic ecps_pkg::req_t random_req();
		ecps_pkg::req_t r;
		r.mode            = ecps_pkg::mode_t'($urandom_range(0, 3));
		r.self_x          = pick_val();
		r.self_y          = pick_val();
		r.self_vx         = pick_val();
		r.self_vy         = pick_val();
		r.other_vx        = pick_val();
		r.other_vy        = pick_val();
		r.other_mass      = pick_mass();
		r.partner_present = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 2))
			0: r.step_time = $urandom;
			1: r.step_time = ecps_pkg::TIMEW'($urandom_range(0, 32'h0004_0000));
			default: r.step_time = ecps_pkg::TIMEW'($urandom_range(0, 3)) << ecps_pkg::FRAC_BITS;
		endcase
		case ($urandom_range(0, 15))
			0: begin
				r.other_x = r.self_x;
				r.other_y = r.self_y;
			end
			1, 2, 3, 4: begin
				r.other_x = pick_val();
				r.other_y = pick_val();
			end
			default: begin
				r.other_x = r.self_x + ecps_pkg::val_t'(
					$signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
				r.other_y = r.self_y + ecps_pkg::val_t'(
					$signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
			end
		endcase
		return r;
	endfunction

	// Present one request, hold it until the unit takes it, then record what
	// it must produce. start stays high across back-to-back requests.
	task automatic send_request(input ecps_pkg::req_t r, input logic known,
			input ecps_pkg::rsp_t answer);
		int gap;
		req   <= r;
		start <= 1'b1;
		do begin
			@(posedge clk);
		end while (busy);
		pending_steps.push_back(known ? answer : step_result(r, mass_now));
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Let the pipeline drain, then change the mass of this particle kind.
	task automatic set_own_mass(input logic [ecps_pkg::MASSW-1:0] m);
		start <= 1'b0;
		while (pending_steps.size() != 0) begin
			@(posedge clk);
		end
		repeat (50) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mass_now  = m;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	// Results are compared in order; the unit cannot be stalled.
	always @(posedge clk) begin
		ecps_pkg::rsp_t want;
		if (arst_n && rsp_strobe) begin
			if (pending_steps.size() == 0) begin
				$error("unexpected result: new_x %h", rsp.new_x);
				fail_count++;
			end else begin
				want = pending_steps.pop_front();
				check_field("new_x", want.new_x, rsp.new_x);
				check_field("new_y", want.new_y, rsp.new_y);
				check_field("new_vx", want.new_vx, rsp.new_vx);
				check_field("new_vy", want.new_vy, rsp.new_vy);
				check_field("other_new_vx", want.other_new_vx, rsp.other_new_vx);
				check_field("other_new_vy", want.other_new_vy, rsp.other_new_vy);
				check_field("coincident", 32'(want.coincident), 32'(rsp.coincident));
			end
		end
	end

	initial begin
		ecps_pkg::req_t             r;
		ecps_pkg::rsp_t             none;
		logic [ecps_pkg::MASSW-1:0] masses[4];
		fail_count  = 0;
		mass_now    = ecps_pkg::OWN_MASS_RESET;
		none        = '0;
		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;

		// Reflections of the extremes, including negating the minimum.
		r = make_req(ecps_pkg::MODE_REFLECTX, ONE, -ONE, VMIN, ONE, 0, 0, 5, 6, 1, 0, 1);
		none = unchanged(r, 1'b0);
		none.new_vx = VMAX;
		add_row(r, 1'b1, none);
		r = make_req(ecps_pkg::MODE_REFLECTY, VMAX, VMIN, ONE, VMAX, 3, 4, VMIN, VMAX, 65535,
			'1, 0);
		none = unchanged(r, 1'b0);
		none.new_vy = -VMAX;
		add_row(r, 1'b1, none);
		r = make_req(ecps_pkg::MODE_REFLECTY, 0, 0, 0, VMIN, 0, 0, 0, 0, 1, 0, 1);
		add_row(r, 1'b0, none);
		// Advance with zero time leaves everything in place.
		r = make_req(ecps_pkg::MODE_ADVANCE, VMAX, VMIN, VMAX, VMIN, 1, 2, 3, 4, 7, 0, 1);
		add_row(r, 1'b1, unchanged(r, 1'b0));
		// Advance that saturates both ways, and one that rounds a half.
		r = make_req(ecps_pkg::MODE_ADVANCE, VMAX - 5, VMIN + 5, VMAX, VMIN, 0, 0, 0, 0, 1,
			'1, 0);
		add_row(r, 1'b0, none);
		r = make_req(ecps_pkg::MODE_ADVANCE, 0, 0, 1, -1, 0, 0, 0, 0, 1, 32'h0000_8000, 1);
		add_row(r, 1'b0, none);
		r = make_req(ecps_pkg::MODE_ADVANCE, -ONE, ONE, 3 * ONE, -2 * ONE, 0, 0, 0, 0, 1,
			32'h0001_8000, 1);
		add_row(r, 1'b0, none);
		// A collision without a partner changes nothing.
		r = make_req(ecps_pkg::MODE_COLLIDE, 0, 0, ONE, 0, ONE, 0, -ONE, 0, 10, 0, 0);
		add_row(r, 1'b1, unchanged(r, 1'b0));
		// Coincident centers are flagged and pass the velocities.
		r = make_req(ecps_pkg::MODE_COLLIDE, ONE, ONE, ONE, -ONE, ONE, ONE, 0, VMAX, 9, 0, 1);
		add_row(r, 1'b1, unchanged(r, 1'b1));
		r = make_req(ecps_pkg::MODE_COLLIDE, VMIN, VMAX, VMIN, VMAX, VMIN, VMAX, VMAX, VMIN,
			65535, '1, 1);
		add_row(r, 1'b1, unchanged(r, 1'b1));
		// Head-on and oblique collisions, equal and extreme masses.
		r = make_req(ecps_pkg::MODE_COLLIDE, 0, 0, ONE, 0, ONE, 0, -ONE, 0, 10, 0, 1);
		add_row(r, 1'b0, none);
		r = make_req(ecps_pkg::MODE_COLLIDE, 0, 0, ONE, ONE, ONE, ONE, 0, 0, 1, 0, 1);
		add_row(r, 1'b0, none);
		r = make_req(ecps_pkg::MODE_COLLIDE, 0, 0, 3 * ONE, -ONE, 2 * ONE, ONE, -ONE,
			2 * ONE, 65535, 0, 1);
		add_row(r, 1'b0, none);
		// Far apart centers at opposite corners with extreme velocities.
		r = make_req(ecps_pkg::MODE_COLLIDE, VMIN, VMIN, VMAX, VMAX, VMAX, VMAX, VMIN, VMIN,
			65535, 0, 1);
		add_row(r, 1'b0, none);
		// Tiny distance with huge velocity difference saturates.
		r = make_req(ecps_pkg::MODE_COLLIDE, 0, 0, VMAX, VMIN, 1, 0, VMIN, VMAX, 1, 0, 1);
		add_row(r, 1'b0, none);
		r = make_req(ecps_pkg::MODE_COLLIDE, 5, -7, -ONE, ONE, 4, -9, ONE, VMIN, 300, '1, 1);
		add_row(r, 1'b0, none);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs with the mass left at its reset value.
		for (int i = 0; i < dir_req.size(); i++) begin
			send_request(dir_req[i], dir_known[i], dir_rsp[i]);
		end

		// Random part in phases, the first under the reset mass and each later one under a new mass, extremes included.
		masses[0] = ecps_pkg::MASSW'(1);
		masses[1] = ecps_pkg::MASSW'(65535);
		masses[2] = pick_mass();
		masses[3] = ecps_pkg::MASSW'($urandom_range(2, 100));
		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				set_own_mass(masses[p - 1]);
			end
			for (int n = 0; n < 350; n++) begin
				send_request(random_req(), 1'b0, none);
			end
		end

		start <= 1'b0;
		while (pending_steps.size() != 0) begin
			@(posedge clk);
		end
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending_steps.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#40000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
